// ----- design/bhs_pkg.sv -----
// Shared types for the binary heap sort block.
package bhs_pkg;

   typedef logic signed [31:0] value_type;

   localparam value_type VALUE_MIN = 32'sh8000_0000;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      logic      insert;
      logic      shift;
      value_type item;
   } cell_ctrl_type;

endpackage

// ----- design/bhs_cell.sv -----
// One cell of the sorting chain: holds one element and trades with its neighbors.
module bhs_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  bhs_pkg::cell_ctrl_type ctrl,
   input  logic                   left_valid,
   input  bhs_pkg::value_type     left_value,
   input  logic                   right_valid,
   input  bhs_pkg::value_type     right_value,
   output logic                   own_valid,
   output bhs_pkg::value_type     own_value
);

   logic               valid_ff, valid_in;
   bhs_pkg::value_type value_ff, value_in;
   logic               keep;
   logic               left_le;

   // Cells stay sorted ascending from the head; invalid cells sit at the tail.
   assign keep    = valid_ff && (value_ff <= ctrl.item);
   assign left_le = left_valid && (left_value <= ctrl.item);

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (ctrl.insert) begin
         if (!keep) begin
            if (left_le) begin
               valid_in = 1'b1;
               value_in = ctrl.item;
            end else begin
               valid_in = left_valid;
               value_in = left_value;
            end
         end
      end else if (ctrl.shift) begin
         valid_in = right_valid;
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign own_valid = valid_ff;
   assign own_value = value_ff;

endmodule

// ----- design/binary_heap_sort_top.sv -----
// Top level of the sorter: a chain of insertion cells plus load/drain control.
//
// Usage: send a set of signed 32-bit values on the req_ channel, one per
// transaction, with req_is_last high on the final one. Each value is slotted
// into its sorted place in the cell chain in the cycle it is accepted. Values
// beyond MAX_ELEMS are dropped and every result of that set carries
// rsp_overflow.
// The cycle after the last transaction is accepted, the set starts to leave
// on the rsp_ channel in ascending order, one result per cycle while rsp_stall
// is low, the head cell acting as output register; rsp_end_of_set marks the
// largest element.
// req_stall is high while a set drains; no new values are taken until the
// final result has been accepted. When rsp_stall is high the chain holds and
// the shown result stays unchanged. Reset empties the chain and clears the
// overflow flag; it takes effect at once with no clearing pass.
module binary_heap_sort_top #(
   parameter int MAX_ELEMS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_value,
   input  logic               req_is_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_sorted_value,
   output logic               rsp_end_of_set,
   output logic               rsp_overflow
);

   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } state_type;

   state_type              state_ff;
   logic                   dropped_ff;
   logic                   req_take;
   logic                   rsp_take;
   logic                   full;
   bhs_pkg::cell_ctrl_type ctrl;
   logic                   cell_valid [MAX_ELEMS];
   bhs_pkg::value_type     cell_value [MAX_ELEMS];

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;
   assign full     = cell_valid[MAX_ELEMS-1];

   assign ctrl.insert = req_take && !full;
   assign ctrl.shift  = rsp_take;
   assign ctrl.item   = req_value;

   for (genvar i = 0; i < MAX_ELEMS; i++) begin : g_cell
      logic               lv, rv;
      bhs_pkg::value_type lval, rval;
      if (i == 0) begin : g_head
         // Head sees a valid minimum on its left, so it takes the item whenever it does not keep its own value.
         assign lv   = 1'b1;
         assign lval = bhs_pkg::VALUE_MIN;
      end else begin : g_mid
         assign lv   = cell_valid[i-1];
         assign lval = cell_value[i-1];
      end
      if (i == MAX_ELEMS - 1) begin : g_tail
         assign rv   = 1'b0;
         assign rval = '0;
      end else begin : g_body
         assign rv   = cell_valid[i+1];
         assign rval = cell_value[i+1];
      end
      bhs_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_valid  (lv),
         .left_value  (lval),
         .right_valid (rv),
         .right_value (rval),
         .own_valid   (cell_valid[i]),
         .own_value   (cell_value[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         dropped_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_LOAD: begin
               if (req_take) begin
                  if (full) begin
                     dropped_ff <= 1'b1;
                  end
                  if (req_is_last) begin
                     state_ff <= ST_DRAIN;
                  end
               end
            end
            ST_DRAIN: begin
               if (rsp_take && !cell_valid[1]) begin
                  state_ff   <= ST_LOAD;
                  dropped_ff <= 1'b0;
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

   assign req_stall        = (state_ff == ST_DRAIN);
   assign rsp_valid        = (state_ff == ST_DRAIN);
   assign rsp_sorted_value = cell_value[0];
   assign rsp_end_of_set   = !cell_valid[1];
   assign rsp_overflow     = dropped_ff;

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for binary_heap_sort_top: directed and random sets checked against a heap sort.
module testbench;

   localparam int SET_CAPACITY = 64;
   localparam int RANDOM_ITEMS = 30;
   localparam bhs_pkg::value_type VALUE_MAX = 32'sh7fff_ffff;

   typedef struct {
      bhs_pkg::value_type value;
      logic               end_of_set;
      logic               overflow;
   } sorted_result_type;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   bhs_pkg::value_type req_value = '0;
   logic               req_is_last = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   bhs_pkg::value_type rsp_sorted_value;
   logic               rsp_end_of_set;
   logic               rsp_overflow;

   sorted_result_type  pending_sorted[$];
   sorted_result_type  want_result;
   bhs_pkg::value_type set_values[$];
   logic               set_dropped = 1'b0;
   bhs_pkg::value_type heap_buf[SET_CAPACITY];
   bhs_pkg::value_type prev_value = '0;
   int                 mismatches = 0;
   int                 burst_left = 0;
   stall_mode_type     stall_mode = STALL_NONE;
   int                 mode_left = 0;

   binary_heap_sort_top #(.MAX_ELEMS(SET_CAPACITY)) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .req_is_last      (req_is_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_end_of_set   (rsp_end_of_set),
      .rsp_overflow     (rsp_overflow)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void sift_heap(input int root, input int len);
      int                 hole;
      int                 kid;
      bhs_pkg::value_type key;
      hole = root;
      key  = heap_buf[root];
      while (hole * 2 + 1 < len) begin
         kid = hole * 2 + 1;
         if (kid + 1 < len && heap_buf[kid] < heap_buf[kid + 1])
            kid++;
         if (key >= heap_buf[kid])
            break;
         heap_buf[hole] = heap_buf[kid];
         hole = kid;
      end
      heap_buf[hole] = key;
   endfunction

   // Store or drop one value; the last one sorts the set and queues its results.
   function automatic void collect_value(input bhs_pkg::value_type v, input logic is_last);
      int                 n;
      bhs_pkg::value_type tmp;
      sorted_result_type  r;
      if (set_values.size() < SET_CAPACITY)
         set_values.push_back(v);
      else
         set_dropped = 1'b1;
      if (!is_last)
         return;
      n = set_values.size();
      for (int i = 0; i < n; i++)
         heap_buf[i] = set_values[i];
      for (int i = n / 2; i > 0; i--)
         sift_heap(i - 1, n);
      for (int i = n - 1; i > 0; i--) begin
         tmp         = heap_buf[0];
         heap_buf[0] = heap_buf[i];
         heap_buf[i] = tmp;
         sift_heap(0, i);
      end
      for (int k = 0; k < n; k++) begin
         r.value      = heap_buf[k];
         r.end_of_set = (k == n - 1);
         r.overflow   = set_dropped;
         pending_sorted.push_back(r);
      end
      set_values.delete();
      set_dropped = 1'b0;
   endfunction

   function automatic bhs_pkg::value_type pick_value();
      bhs_pkg::value_type v;
      case ($urandom_range(0, 9))
         0: v = bhs_pkg::VALUE_MIN;
         1: v = VALUE_MAX;
         2: v = bhs_pkg::value_type'(int'($urandom_range(0, 4)) - 2);
         3: v = prev_value;   // duplicates
         default: v = $urandom;
      endcase
      prev_value = v;
      return v;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_item(input bhs_pkg::value_type v, input logic is_last);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 20);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_value   <= v;
      req_is_last <= is_last;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      collect_value(v, is_last);
      @(negedge clock);
   endtask

   task automatic send_list(input bhs_pkg::value_type vals[$]);
      for (int i = 0; i < vals.size(); i++)
         send_item(vals[i], i == vals.size() - 1);
   endtask

   task automatic send_set(input int count);
      for (int i = 0; i < count; i++)
         send_item(pick_value(), i == count - 1);
   endtask

   task automatic drain_pause();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_sorted.size() != 0)
         @(negedge clock);
      burst_left = 0;
   endtask

   task automatic test_single_element();
      send_item('0, 1'b1);
      send_item(bhs_pkg::VALUE_MIN, 1'b1);
      send_item(VALUE_MAX, 1'b1);
   endtask

   task automatic test_extremes();
      send_list('{VALUE_MAX, bhs_pkg::VALUE_MIN, 0, -1, 1, bhs_pkg::VALUE_MIN + 1,
                  VALUE_MAX - 1});
   endtask

   task automatic test_equal_values();
      send_list('{5, -5, 5, 5, -5, bhs_pkg::VALUE_MIN, bhs_pkg::VALUE_MIN});
   endtask

   task automatic test_pairs();
      send_list('{3, -3});
      send_list('{-3, 3});
   endtask

   // Exactly full, then past capacity with the last transaction dropped too.
   task automatic test_capacity();
      send_set(SET_CAPACITY);
      drain_pause();
      send_set(SET_CAPACITY + 3);
      send_list('{7, -7});
   endtask

   task automatic test_random_sets();
      int sent;
      int n;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, SET_CAPACITY + 4)
                                         : $urandom_range(1, 12);
         if (n > RANDOM_ITEMS - sent)
            n = RANDOM_ITEMS - sent;
         send_set(n);
         sent += n;
         if ($urandom_range(0, 7) == 0)
            drain_pause();
      end
   endtask

   // Receiver back-pressure, switching between quiet, light and heavy stretches.
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 2));
         mode_left  = $urandom_range(16, 80);
      end
      mode_left--;
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         default:     rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_sorted.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: value %0d end %b overflow %b",
                        rsp_sorted_value, rsp_end_of_set, rsp_overflow);
         end else begin
            want_result = pending_sorted.pop_front();
            if (rsp_sorted_value !== want_result.value ||
                rsp_end_of_set !== want_result.end_of_set ||
                rsp_overflow !== want_result.overflow) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected value %0d end %b overflow %b, got %0d %b %b",
                           want_result.value, want_result.end_of_set,
                           want_result.overflow, rsp_sorted_value, rsp_end_of_set,
                           rsp_overflow);
            end
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_single_element();
      test_extremes();
      drain_pause();
      test_equal_values();
      test_pairs();
      test_capacity();
      test_random_sets();
      drain_pause();
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
